// ===== rtl/asc_pkg.sv =====
package asc_pkg;

  localparam int ANGLE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int SCALE_WIDTH   = 16;
  localparam int SCALE_FRAC    = 15;
  localparam int PROD_WIDTH    = ANGLE_WIDTH + SCALE_WIDTH;

  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(5461);

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [SCALE_WIDTH-1:0] scale_t;

  typedef struct packed {
    angle_t a0;
    angle_t a1;
    angle_t a2;
    angle_t a3;
    logic   run_last;
    logic   seq_end;
  } seg_job_t;

  typedef struct packed {
    angle_t start_point;
    angle_t first_handle;
    angle_t second_handle;
    angle_t end_point;
    logic   run_last;
    logic   sequence_end;
  } seg_out_t;

endpackage

// ===== rtl/asc_stream_if.sv =====
interface asc_angle_if import asc_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t angle;
  logic   is_last;

  modport source (output valid, output angle, output is_last, input ready);
  modport sink (input valid, input angle, input is_last, output ready);
endinterface

interface asc_seg_if import asc_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t start_point;
  angle_t first_handle;
  angle_t second_handle;
  angle_t end_point;
  logic   run_last;
  logic   sequence_end;

  modport source (
    output valid, output start_point, output first_handle, output second_handle,
    output end_point, output run_last, output sequence_end, input ready
  );
  modport sink (
    input valid, input start_point, input first_handle, input second_handle,
    input end_point, input run_last, input sequence_end, output ready
  );
endinterface

// ===== rtl/angle_spline_control_points_unit.sv =====
// Angle keyframes in signed Q16.16 turns go in, one transaction per cycle; each
// angle is unwrapped against the previous one and cubic Bezier segments
// (start, two handles, end) come out, the handles scaled by the signed Q1.15
// register written through cfg_we/cfg_wdata (reset 5461, about 1/6). An angle
// yields zero, one or two segments: the first two angles of a sequence yield
// none unless marked last, later ones yield the segment ending at the angle
// before, and a last angle adds the closing segment. A segment is registered
// in seg_r and then in the output register; with the output drained every
// cycle the unit accepts one angle per cycle, except that an angle yielding
// two segments holds the input while the single segment datapath (two
// multipliers feeding the output register) emits the second segment.
module angle_spline_control_points_unit import asc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [SCALE_WIDTH-1:0] cfg_wdata,
  asc_angle_if.sink              in_chan,
  asc_seg_if.source              out_chan
);

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_MANY = 2'd3;

  scale_t   scale_r;
  logic [1:0] seen_r, seen_nxt;
  angle_t   win0_r, win1_r, win2_r;

  logic     seg_valid_r, extra_valid_r, out_valid_r;
  seg_job_t seg_r, extra_r;
  seg_out_t out_r, out_nxt;

  logic     in_fire, seg_adv;
  angle_t   diff, frac_ext, x, p0;
  seg_job_t job0, job1;
  logic     job0_valid, job1_valid;

  angle_t   d_first, d_second;
  logic signed [PROD_WIDTH-1:0] prod_first, prod_second;

  assign seg_adv        = seg_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !extra_valid_r && (!seg_valid_r || seg_adv);
  assign in_fire        = in_chan.valid && in_chan.ready;

  assign diff     = in_chan.angle - win2_r;
  assign frac_ext = {{(ANGLE_WIDTH-FRACTION_BITS){diff[FRACTION_BITS-1]}},
                     diff[FRACTION_BITS-1:0]};
  assign x        = (seen_r == SEEN_NONE) ? in_chan.angle : win2_r + frac_ext;
  assign p0       = (seen_r == SEEN_TWO) ? win1_r : win0_r;

  always_comb begin
    job0       = '0;
    job1       = '0;
    job0_valid = 1'b0;
    job1_valid = 1'b0;
    unique case (seen_r) inside
      SEEN_NONE: begin
        job0_valid = in_chan.is_last;
        job0 = '{a0: x, a1: x, a2: x, a3: x, run_last: 1'b1, seq_end: 1'b1};
      end
      SEEN_ONE: begin
        job0_valid = in_chan.is_last;
        job0 = '{a0: win2_r, a1: win2_r, a2: x, a3: x, run_last: 1'b1, seq_end: 1'b1};
      end
      SEEN_TWO, SEEN_MANY: begin
        job0_valid = 1'b1;
        job0 = '{a0: p0, a1: win1_r, a2: win2_r, a3: x,
                 run_last: !in_chan.is_last, seq_end: 1'b0};
        job1_valid = in_chan.is_last;
        job1 = '{a0: win1_r, a1: win2_r, a2: x, a3: x, run_last: 1'b1, seq_end: 1'b1};
      end
      default: begin
        job0_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (in_chan.is_last) begin
      seen_nxt = SEEN_NONE;
    end else if (seen_r == SEEN_MANY) begin
      seen_nxt = SEEN_MANY;
    end else begin
      seen_nxt = seen_r + 2'd1;
    end
  end

  assign d_first     = seg_r.a2 - seg_r.a0;
  assign d_second    = seg_r.a3 - seg_r.a1;
  assign prod_first  = d_first * scale_r;
  assign prod_second = d_second * scale_r;

  always_comb begin
    out_nxt.start_point   = seg_r.a1;
    out_nxt.first_handle  = seg_r.a1 + prod_first[SCALE_FRAC +: ANGLE_WIDTH];
    out_nxt.second_handle = seg_r.a2 - prod_second[SCALE_FRAC +: ANGLE_WIDTH];
    out_nxt.end_point     = seg_r.a2;
    out_nxt.run_last      = seg_r.run_last;
    out_nxt.sequence_end  = seg_r.seq_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= SEEN_NONE;
    end else if (in_fire) begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win0_r <= win1_r;
      win1_r <= win2_r;
      win2_r <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_valid_r   <= 1'b0;
      extra_valid_r <= 1'b0;
    end else if (extra_valid_r) begin
      if (seg_adv) begin
        extra_valid_r <= 1'b0;
      end
    end else if (in_fire && job0_valid) begin
      seg_valid_r   <= 1'b1;
      extra_valid_r <= job1_valid;
    end else if (seg_adv) begin
      seg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (extra_valid_r) begin
      if (seg_adv) begin
        seg_r <= extra_r;
      end
    end else if (in_fire) begin
      seg_r   <= job0;
      extra_r <= job1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seg_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.start_point   = out_r.start_point;
  assign out_chan.first_handle  = out_r.first_handle;
  assign out_chan.second_handle = out_r.second_handle;
  assign out_chan.end_point     = out_r.end_point;
  assign out_chan.run_last      = out_r.run_last;
  assign out_chan.sequence_end  = out_r.sequence_end;

  a_extra_needs_seg: assert property (@(posedge clk) disable iff (!rst_n)
    extra_valid_r |-> seg_valid_r)
    else $error("second segment pending without a first");

  a_seq_end_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.sequence_end |-> out_r.run_last)
    else $error("sequence end on a segment that is not the last of its transaction");

  a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.is_last |=> seen_r == SEEN_NONE)
    else $error("sequence count not cleared after last angle");

endmodule

// ===== tb/angle_spline_control_points_unit_tb.sv =====
module angle_spline_control_points_unit_tb import asc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    angle_t   angle;
    logic     is_last;
    logic     literal;
    seg_out_t seg;
  } angle_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [SCALE_WIDTH-1:0] cfg_wdata;

  asc_angle_if in_if ();
  asc_seg_if   out_if ();

  angle_spline_control_points_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  scale_t     tangent_scale;
  angle_t     angle_hist [3];
  logic [1:0] angles_in_seq;

  seg_out_t pending_segments [$];
  int       mismatches;
  int       segments_checked;
  int       angles_sent;
  int       sequences_sent;
  int       cycle_count;
  int       hold_requests;
  int       holds_done;
  bit       idling_on;

  angle_row_t angle_rows [15] = '{
    '{32'sh00000000, 1'b1, 1'b1,
      '{32'sh00000000, 32'sh00000000, 32'sh00000000, 32'sh00000000, 1'b1, 1'b1}},
    '{32'sh7FFFFFFF, 1'b1, 1'b1,
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 1'b1}},
    '{32'sh80000000, 1'b1, 1'b1,
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, 1'b1}},
    '{32'sh00010000, 1'b0, 1'b0, '0},
    '{32'sh00018000, 1'b1, 1'b0, '0},
    '{32'sh7FFF0000, 1'b0, 1'b0, '0},
    '{32'sh80010000, 1'b0, 1'b0, '0},
    '{32'sh00008000, 1'b1, 1'b0, '0},
    '{32'sh00000000, 1'b0, 1'b0, '0},
    '{32'sh00007FFF, 1'b0, 1'b0, '0},
    '{32'shFFFF8000, 1'b0, 1'b0, '0},
    '{32'sh12345678, 1'b0, 1'b0, '0},
    '{32'shEDCBA987, 1'b1, 1'b0, '0},
    '{32'shFFFFFFFF, 1'b0, 1'b0, '0},
    '{32'sh00000000, 1'b1, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  function automatic angle_t scaled_diff(angle_t diff);
    logic signed [PROD_WIDTH-1:0] d;
    logic signed [PROD_WIDTH-1:0] s;
    logic signed [PROD_WIDTH-1:0] p;
    d = diff;
    s = tangent_scale;
    p = d * s;
    p = p >>> SCALE_FRAC;
    return p[ANGLE_WIDTH-1:0];
  endfunction

  function automatic angle_t unwrap_angle(angle_t prev, angle_t raw);
    logic [ANGLE_WIDTH-1:0] d;
    angle_t                 f;
    d = raw - prev;
    f = {{(ANGLE_WIDTH-FRACTION_BITS){d[FRACTION_BITS-1]}}, d[FRACTION_BITS-1:0]};
    return prev + f;
  endfunction

  function automatic seg_out_t bezier_segment(angle_t a0, angle_t a1, angle_t a2,
                                              angle_t a3, logic seq_end);
    seg_out_t r;
    r.start_point   = a1;
    r.first_handle  = a1 + scaled_diff(a2 - a0);
    r.second_handle = a2 - scaled_diff(a3 - a1);
    r.end_point     = a2;
    r.run_last      = 1'b0;
    r.sequence_end  = seq_end;
    return r;
  endfunction

  task automatic predict_segments(input angle_t raw, input logic last, output int n,
                                  output seg_out_t r0, output seg_out_t r1);
    angle_t     x;
    angle_t     p0;
    logic [1:0] c;
    c  = angles_in_seq;
    x  = raw;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (c != 2'd0) begin
      x = unwrap_angle(angle_hist[2], raw);
    end
    case (c)
      2'd0: begin
        if (last) begin
          r0 = bezier_segment(x, x, x, x, 1'b1);
          n  = 1;
        end
      end
      2'd1: begin
        if (last) begin
          r0 = bezier_segment(angle_hist[2], angle_hist[2], x, x, 1'b1);
          n  = 1;
        end
      end
      default: begin
        p0 = (c == 2'd2) ? angle_hist[1] : angle_hist[0];
        r0 = bezier_segment(p0, angle_hist[1], angle_hist[2], x, 1'b0);
        n  = 1;
        if (last) begin
          r1 = bezier_segment(angle_hist[1], angle_hist[2], x, x, 1'b1);
          n  = 2;
        end
      end
    endcase
    if (n == 1) r0.run_last = 1'b1;
    if (n == 2) r1.run_last = 1'b1;
    angle_hist[0] = angle_hist[1];
    angle_hist[1] = angle_hist[2];
    angle_hist[2] = x;
    if (last) begin
      angles_in_seq = 2'd0;
    end else if (c != 2'd3) begin
      angles_in_seq = c + 2'd1;
    end
  endtask

  task automatic send_angle(input angle_t angle, input logic last, input logic literal,
                            input seg_out_t lit_seg);
    int       gap;
    int       n;
    seg_out_t r0;
    seg_out_t r1;
    gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.angle   <= angle;
    in_if.is_last <= last;
    do @(posedge clk); while (!in_if.ready);
    predict_segments(angle, last, n, r0, r1);
    if (literal) begin
      pending_segments.push_back(lit_seg);
    end else begin
      if (n > 0) pending_segments.push_back(r0);
      if (n > 1) pending_segments.push_back(r1);
    end
    angles_sent++;
    if (last) sequences_sent++;
  endtask

  task automatic wait_drained();
    while (pending_segments.size() != 0) @(posedge clk);
  endtask

  task automatic write_scale(input scale_t value);
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we        <= 1'b0;
    tangent_scale  = value;
  endtask

  function automatic angle_t pick_angle(angle_t prev);
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      return prev + angle_t'($urandom_range(0, 32'h3FFFF)) - angle_t'(32'h20000);
    end else if (kind < 17) begin
      return angle_t'($urandom);
    end
    case ($urandom_range(0, 5))
      0:       return 32'sh00000000;
      1:       return 32'sh7FFFFFFF;
      2:       return 32'sh80000000;
      3:       return 32'shFFFFFFFF;
      4:       return prev + 32'sh00008000;
      default: return prev - 32'sh00008000;
    endcase
  endfunction

  task automatic run_sequences(input int n_items, input int hold_at, input int pause_at);
    int     count;
    int     len;
    angle_t raw;
    count = 0;
    raw   = angle_t'($urandom);
    while (count < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if (count == hold_at) hold_requests++;
        if (count == pause_at) begin
          @(negedge clk);
          in_if.valid <= 1'b0;
          wait_drained();
        end
        raw = pick_angle(raw);
        send_angle(raw, i == len - 1, 1'b0, '0);
        count++;
      end
    end
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    seg_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_segments.size() == 0) begin
        $display("%0t: unexpected segment, expected none, actual %h %h %h %h %b %b",
                 $time, out_if.start_point, out_if.first_handle, out_if.second_handle,
                 out_if.end_point, out_if.run_last, out_if.sequence_end);
        mismatches++;
      end else begin
        want = pending_segments.pop_front();
        check_field("start_point", want.start_point, out_if.start_point);
        check_field("first_handle", want.first_handle, out_if.first_handle);
        check_field("second_handle", want.second_handle, out_if.second_handle);
        check_field("end_point", want.end_point, out_if.end_point);
        check_field("run_last", 32'(want.run_last), 32'(out_if.run_last));
        check_field("sequence_end", 32'(want.sequence_end), 32'(out_if.sequence_end));
        segments_checked++;
      end
    end
  end

  initial begin
    int hold_left;
    int stall_left;
    hold_left    = 0;
    stall_left   = 0;
    holds_done   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.angle      = '0;
    in_if.is_last    = 1'b0;
    tangent_scale    = scale_t'(SCALE_RESET);
    angle_hist       = '{default: '0};
    angles_in_seq    = 2'd0;
    mismatches       = 0;
    segments_checked = 0;
    angles_sent      = 0;
    sequences_sent   = 0;
    hold_requests    = 0;
    idling_on        = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (angle_rows[i]) begin
      send_angle(angle_rows[i].angle, angle_rows[i].is_last, angle_rows[i].literal,
                 angle_rows[i].seg);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    write_scale(16'sh7FFF);
    run_sequences(300, 100, -1);
    write_scale(-16'sh8000);
    run_sequences(300, -1, 150);
    write_scale(16'sh0000);
    run_sequences(200, -1, -1);
    write_scale(scale_t'($urandom_range(0, 65535)));
    run_sequences(300, 200, 60);
    write_scale(scale_t'(SCALE_RESET));
    idling_on = 1'b0;
    run_sequences(400, -1, -1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d angles in %0d sequences, checked %0d segments", angles_sent,
             sequences_sent, segments_checked);
    $display("Tangent scale runs: reset, max, min, zero, random; long output hold-offs");
    if (mismatches == 0 && pending_segments.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/asc_pkg.sv
rtl/asc_stream_if.sv
rtl/angle_spline_control_points_unit.sv
tb/angle_spline_control_points_unit_tb.sv
